### rtl/core/imuafp_pkg.sv
// ----------------------------------------------------------------------------
// imuafp_pkg
// shared types and constants of the angle frame parser
// ----------------------------------------------------------------------------
package imuafp_pkg;

  localparam int unsigned DATA_LEN_DEF = 8;
  localparam int unsigned RAW_BYTES    = 6;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned ANGLE_W      = 18;
  localparam int unsigned MAG_W        = 17;
  localparam int unsigned KPART_W      = 23;
  localparam int unsigned PROD_W       = MAG_W + KPART_W;
  localparam int unsigned FRAC_SHIFT   = 44;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  // pi scaled by 2^44, split into two halves for narrow multipliers
  localparam logic [45:0] PI_Q44 = 46'h3243F6A8885A;
  localparam logic [KPART_W-1:0] K_HI = PI_Q44[45:23];
  localparam logic [KPART_W-1:0] K_LO = PI_Q44[22:0];

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_TYPE,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } raw_frame_t;

  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage

### rtl/core/imu_angle_frame_parser_core.sv
// ----------------------------------------------------------------------------
// imu_angle_frame_parser_core
// serial angle frame parser with 8-bit additive checksum and pi scaling
// ----------------------------------------------------------------------------
// in_*  : one received serial byte per transaction, taken whenever the
//         frame queue has room (one byte per cycle sustained)
// out_* : one transaction per frame with a good checksum, carrying roll,
//         pitch and yaw in radians, signed, 15 fraction bits
// a frame is 0x55, 0x53, DATA_LEN data bytes and a checksum byte; a bad
// checksum or a wrong type byte drops the frame with no output
// the edge that takes the checksum byte writes the frame into the queue;
// it then passes the multiply stage and the round and sign stage, and
// out_tvalid rises with the latter; a frame takes DATA_LEN + 3 bytes,
// so output rate is bounded by the byte stream
// when out_tready is low the scaler holds its result, frames pile up in the
// two-entry queue, and only when that is full does in_tready drop
// synchronous reset returns the parser to the header hunt and empties
// the queue and the pipeline
// ----------------------------------------------------------------------------
module imu_angle_frame_parser_core
  import imuafp_pkg::*;
#(
  parameter int unsigned DATA_LEN    = DATA_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // roll_angle[17:0], pitch_angle[35:18], yaw_angle[53:36]
);

  queue_ctl_t q_ctl;
  raw_frame_t wr_frame;
  raw_frame_t rd_frame;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic signed [ANGLE_W-1:0] roll_angle;
  logic signed [ANGLE_W-1:0] pitch_angle;
  logic signed [ANGLE_W-1:0] yaw_angle;

  imuafp_front #(
    .DATA_LEN (DATA_LEN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_ctl     (q_ctl),
    .q_frame   (wr_frame)
  );

  imuafp_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_ctl   (q_ctl),
    .wr_frame (wr_frame),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_frame (rd_frame)
  );

  imuafp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_frame     (rd_frame),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle)
  );

  assign out_tdata = {2'b00, yaw_angle, pitch_angle, roll_angle};

endmodule

### rtl/core/imuafp_front.sv
// ----------------------------------------------------------------------------
// imuafp_front
// byte parser: header and type check, data capture, running checksum
// ----------------------------------------------------------------------------
module imuafp_front
  import imuafp_pkg::*;
#(
  parameter int unsigned DATA_LEN = DATA_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output queue_ctl_t q_ctl,
  output raw_frame_t q_frame
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] pos_r, pos_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] data_r [RAW_BYTES];
  logic       in_fire;
  logic       push;

  assign in_tready = ~q_full;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= 4'd0;
      sum_r   <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && phase_r == PH_DATA && pos_r < 4'(RAW_BYTES)) begin
      data_r[pos_r[2:0]] <= in_tdata;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    push      = 1'b0;
    if (in_fire) begin
      case (phase_r)
        PH_HUNT: begin
          if (in_tdata == HDR_BYTE) begin
            sum_nxt   = in_tdata;
            pos_nxt   = 4'd0;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          pos_nxt = 4'd0;
          if (in_tdata == TYPE_ANGLE) begin
            sum_nxt   = sum_r + in_tdata;
            phase_nxt = PH_DATA;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          sum_nxt = sum_r + in_tdata;
          pos_nxt = pos_r + 4'd1;
          if (pos_nxt >= 4'(DATA_LEN)) begin
            phase_nxt = PH_SUM;
          end
        end
        PH_SUM: begin
          push      = (sum_r == in_tdata);
          pos_nxt   = 4'd0;
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  assign q_ctl.push     = push;
  assign q_ctl.full     = q_full;
  assign q_frame.roll   = {data_r[1], data_r[0]};
  assign q_frame.pitch  = {data_r[3], data_r[2]};
  assign q_frame.yaw    = {data_r[5], data_r[4]};

endmodule

### rtl/core/imuafp_queue.sv
// ----------------------------------------------------------------------------
// imuafp_queue
// short frame queue between parser and scaler
// ----------------------------------------------------------------------------
module imuafp_queue
  import imuafp_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  queue_ctl_t wr_ctl,
  input  raw_frame_t wr_frame,
  output logic       full,
  output logic       rd_valid,
  input  logic       rd_pop,
  output raw_frame_t rd_frame
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  raw_frame_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_frame = mem_r[rd_ptr_r];
  assign do_wr    = wr_ctl.push & ~wr_ctl.full;
  assign do_rd    = rd_pop & rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({do_wr, do_rd})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_frame;
    end
  end

endmodule

### rtl/core/imuafp_back.sv
// ----------------------------------------------------------------------------
// imuafp_back
// two stage scaler: raw angle times pi, rounded half away from zero
// ----------------------------------------------------------------------------
module imuafp_back
  import imuafp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  raw_frame_t                q_frame,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic signed [ANGLE_W-1:0] roll_angle,
  output logic signed [ANGLE_W-1:0] pitch_angle,
  output logic signed [ANGLE_W-1:0] yaw_angle
);

  localparam int unsigned SUM_W = PROD_W + KPART_W + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

  logic [15:0]        raw [3];
  logic [MAG_W-1:0]   mag [3];
  logic [PROD_W-1:0]  p_hi_r [3];
  logic [PROD_W-1:0]  p_lo_r [3];
  logic [2:0]         neg_r;
  logic [ANGLE_W-1:0] angle_r [3];
  logic               s1_valid_r;
  logic               s2_valid_r;
  logic               s2_move;
  logic               s1_move;

  assign raw[0] = q_frame.roll;
  assign raw[1] = q_frame.pitch;
  assign raw[2] = q_frame.yaw;

  assign s2_move = s1_valid_r & (~s2_valid_r | res_ready);
  assign s1_move = ~s1_valid_r | s2_move;
  assign q_pop   = s1_move & q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        s1_valid_r <= q_valid;
      end
      if (~s2_valid_r | res_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic [SUM_W-1:0]   acc;
    logic [ANGLE_W-1:0] mag_q;

    assign mag[i] = raw[i][15] ? (MAG_W'(17'h10000) - {1'b0, raw[i]}) : {1'b0, raw[i]};
    assign acc    = {SUM_W'(p_hi_r[i]) << KPART_W} + SUM_W'(p_lo_r[i]) + HALF;
    assign mag_q  = acc[FRAC_SHIFT +: ANGLE_W];

    always_ff @(posedge clk) begin
      if (q_pop) begin
        p_hi_r[i] <= PROD_W'(mag[i]) * PROD_W'(K_HI);
        p_lo_r[i] <= PROD_W'(mag[i]) * PROD_W'(K_LO);
        neg_r[i]  <= raw[i][15];
      end
      if (s2_move) begin
        angle_r[i] <= neg_r[i] ? (ANGLE_W'(0) - mag_q) : mag_q;
      end
    end
  end

  assign res_valid   = s2_valid_r;
  assign roll_angle  = angle_r[0];
  assign pitch_angle = angle_r[1];
  assign yaw_angle   = angle_r[2];

endmodule
